// ----- hdl/frr_pkg.sv -----
// ----------------------------------------------------------------------------
// frr_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the framed
// request receiver.
// ----------------------------------------------------------------------------
package frr_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int IDX_W = 7;

	localparam logic [7:0]  HDR_BYTE  = 8'h3A;
	localparam logic [7:0]  END_BYTE  = 8'h0A;
	localparam logic [7:0]  ACK_BYTE  = 8'hAA;
	localparam logic [7:0]  NACK_BYTE = 8'hAF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd250;

	localparam logic [1:0] KIND_ACK      = 2'd0;
	localparam logic [1:0] KIND_NACK_CRC = 2'd1;
	localparam logic [1:0] KIND_NACK_TMO = 2'd2;
	localparam logic [1:0] KIND_DROPPED  = 2'd3;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic CFG_IDX_SLAVE_ID = 1'b0;
	localparam logic CFG_IDX_TIMEOUT  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} frr_item_t;

	typedef struct packed {
		logic [1:0] reply_kind;
		logic [7:0] reply_byte;
		logic [7:0] function_code;
		logic [7:0] pdu_length;
	} frr_result_t;

	typedef struct packed {
		logic [7:0]  slave_id;
		logic [15:0] timeout_ticks;
	} frr_cfg_t;

	typedef struct packed {
		logic             in_frame;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       frame_address;
		logic [7:0]       frame_length;
		logic [7:0]       frame_function;
		logic [15:0]      crc_running;
		logic [15:0]      crc_received;
		logic [1:0]       crc_bytes_seen;
		logic [15:0]      idle_ticks;
	} frr_state_t;

	localparam frr_state_t FRAME_CLEAR = '{
		in_frame:       1'b0,
		byte_index:     '0,
		frame_address:  8'h00,
		frame_length:   8'h00,
		frame_function: 8'h00,
		crc_running:    CRC_INIT,
		crc_received:   16'h0000,
		crc_bytes_seen: 2'd0,
		idle_ticks:     16'h0000
	};

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hdl/frr_if.sv -----
// ----------------------------------------------------------------------------
// frr_if
// Valid/ready channels of the framed request receiver: request items,
// reply items and configuration writes.
// ----------------------------------------------------------------------------
interface frr_req_if;
	import frr_pkg::*;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;
	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface frr_rep_if;
	import frr_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] reply_kind;
	logic [7:0] reply_byte;
	logic [7:0] function_code;
	logic [7:0] pdu_length;
	modport source (output valid, output reply_kind, output reply_byte,
		output function_code, output pdu_length, input ready);
	modport sink   (input valid, input reply_kind, input reply_byte,
		input function_code, input pdu_length, output ready);
endinterface

interface frr_cfg_if;
	import frr_pkg::*;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/frr_cfg.sv -----
// ----------------------------------------------------------------------------
// frr_cfg
// Configuration registers: receiver address and frame timeout in ticks.
// ----------------------------------------------------------------------------
module frr_cfg (
	input  logic             clk,
	input  logic             arst_n,
	frr_cfg_if.sink          cfg,
	output frr_pkg::frr_cfg_t regs
);
	import frr_pkg::*;

	frr_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.slave_id      <= 8'h00;
			regs_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IDX_SLAVE_ID: regs_q.slave_id      <= cfg.data[7:0];
				CFG_IDX_TIMEOUT:  regs_q.timeout_ticks <= cfg.data;
				default:          regs_q               <= regs_q;
			endcase
		end
	end

endmodule

// ----- hdl/frr_engine.sv -----
// ----------------------------------------------------------------------------
// frr_engine
// Frame state and per-item decision: header/close detection, byte counting,
// CRC-16/Modbus update, timeout and overflow handling.
// ----------------------------------------------------------------------------
module frr_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  frr_pkg::frr_item_t  item,
	input  frr_pkg::frr_cfg_t   regs,
	output logic                emit,
	output frr_pkg::frr_result_t result
);
	import frr_pkg::*;

	frr_state_t st_q;
	frr_state_t st_nxt;
	logic [16:0] tick_cnt;
	logic [8:0]  idx9;
	logic [8:0]  len9;
	logic [15:0] crc_calc;
	logic        crc_ok;
	logic [7:0]  b;

	assign b        = item.rx_byte;
	assign tick_cnt = {1'b0, st_q.idle_ticks} + 17'd1;
	assign idx9     = {2'b00, st_q.byte_index};
	assign len9     = {1'b0, st_q.frame_length};
	assign crc_calc = (st_q.frame_length == 8'h00) ? CRC_INIT : st_q.crc_running;
	assign crc_ok   = (st_q.crc_bytes_seen == 2'd2) && (crc_calc == st_q.crc_received);

	always_comb begin
		st_nxt = st_q;
		emit   = 1'b0;
		result = '0;
		if (item.req_type == REQ_TICK) begin
			if (st_q.in_frame) begin
				if (tick_cnt >= {1'b0, regs.timeout_ticks}) begin
					st_nxt            = FRAME_CLEAR;
					emit              = 1'b1;
					result.reply_kind = KIND_NACK_TMO;
					result.reply_byte = NACK_BYTE;
				end else begin
					st_nxt.idle_ticks = tick_cnt[15:0];
				end
			end
		end else if (!st_q.in_frame) begin
			if (b == HDR_BYTE) begin
				st_nxt            = FRAME_CLEAR;
				st_nxt.in_frame   = 1'b1;
				st_nxt.byte_index = IDX_W'(1);
			end
		end else begin
			st_nxt.idle_ticks = 16'h0000;
			if (b == END_BYTE) begin
				st_nxt = FRAME_CLEAR;
				if ((st_q.byte_index >= IDX_W'(2)) && (st_q.frame_address == regs.slave_id)) begin
					emit = 1'b1;
					if (crc_ok) begin
						result.reply_kind    = KIND_ACK;
						result.reply_byte    = ACK_BYTE;
						result.function_code = st_q.frame_function;
						result.pdu_length    = st_q.frame_length;
					end else begin
						result.reply_kind = KIND_NACK_CRC;
						result.reply_byte = NACK_BYTE;
					end
				end
			end else if (st_q.byte_index >= IDX_W'(MAX_FRAME_BYTES)) begin
				st_nxt            = FRAME_CLEAR;
				emit              = 1'b1;
				result.reply_kind = KIND_DROPPED;
			end else begin
				st_nxt.byte_index = st_q.byte_index + IDX_W'(1);
				if (st_q.byte_index == IDX_W'(1)) begin
					st_nxt.frame_address = b;
					st_nxt.crc_running   = crc16_byte(CRC_INIT, b);
				end else if (st_q.byte_index == IDX_W'(2)) begin
					st_nxt.frame_length = b;
					if (b >= 8'd2) begin
						st_nxt.crc_running = crc16_byte(st_q.crc_running, b);
					end else if (b == 8'd0) begin
						st_nxt.crc_received   = {st_q.frame_address, 8'h00};
						st_nxt.crc_bytes_seen = 2'd2;
					end else begin
						st_nxt.crc_received   = {b, 8'h00};
						st_nxt.crc_bytes_seen = 2'd1;
					end
				end else if (st_q.byte_index >= IDX_W'(3)) begin
					if (st_q.byte_index == IDX_W'(3)) begin
						st_nxt.frame_function = b;
					end
					if (idx9 <= len9) begin
						st_nxt.crc_running = crc16_byte(st_q.crc_running, b);
					end else if (idx9 == len9 + 9'd1) begin
						st_nxt.crc_received   = {b, 8'h00};
						st_nxt.crc_bytes_seen = 2'd1;
					end else if (idx9 == len9 + 9'd2) begin
						st_nxt.crc_received   = {st_q.crc_received[15:8], b};
						st_nxt.crc_bytes_seen = 2'd2;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FRAME_CLEAR;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

// ----- hdl/framed_request_receiver_crc16_unit.sv -----
// ----------------------------------------------------------------------------
// framed_request_receiver_crc16_unit
// Framed request receiver with CRC-16/Modbus check and tick-driven timeout.
// ----------------------------------------------------------------------------
// Takes one item (a received byte or a timer tick) per clock cycle unless the
// reply output stalls. An accepted item is held in an input register and
// processed once the output register can take its reply; the reply, if any,
// is then held in an output register. Throughput is one item per cycle, set by
// the update of the frame state (byte count and CRC byte step); the input side stalls
// only while the output register holds a reply that has not been taken.
// Configuration writes are taken every cycle and must only be issued while
// no transaction is in flight.
module framed_request_receiver_crc16_unit (
	input  logic      clk,
	input  logic      arst_n,
	frr_req_if.sink   req,
	frr_rep_if.source rep,
	frr_cfg_if.sink   cfg
);
	import frr_pkg::*;

	frr_cfg_t    regs;
	frr_item_t   item_s1;
	logic        valid_s1;
	logic        step;
	logic        emit;
	frr_result_t result;
	frr_result_t rep_q;
	logic        rep_valid_q;

	assign step      = valid_s1 && (!rep_valid_q || rep.ready);
	assign req.ready = !valid_s1 || step;

	frr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	frr_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.regs   (regs),
		.emit   (emit),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.req_type <= req.req_type;
			item_s1.rx_byte  <= req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_q <= 1'b0;
		end else if (step) begin
			rep_valid_q <= emit;
		end else if (rep.ready) begin
			rep_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rep_q <= result;
		end
	end

	assign rep.valid         = rep_valid_q;
	assign rep.reply_kind    = rep_q.reply_kind;
	assign rep.reply_byte    = rep_q.reply_byte;
	assign rep.function_code = rep_q.function_code;
	assign rep.pdu_length    = rep_q.pdu_length;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the framed request receiver against a cycle-free frame predictor.
// A short table of directed bytes and ticks opens, closes, overflows and
// times out frames; then random frames, mostly well formed with correct
// CRC, mixed with corrupted, truncated and noise sequences, run under
// several slave id and timeout settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import frr_pkg::*;

	localparam int N_DIRECTED   = 38;
	localparam int SEG_ITEMS    = 140;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;

	typedef enum logic [0:0] {OP_ITEM, OP_CFG} row_op_t;
	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_FIXED} check_t;

	typedef struct packed {
		row_op_t     op;
		logic        req_type;
		logic        cfg_index;
		logic [15:0] value;
		logic [7:0]  reps;
		check_t      chk;
		logic [1:0]  kind;
		logic [7:0]  rbyte;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	frr_req_if req_ch ();
	frr_rep_if rep_ch ();
	frr_cfg_if cfg_ch ();

	framed_request_receiver_crc16_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rep    (rep_ch),
		.cfg    (cfg_ch)
	);

	// predicted receiver state and register copies
	logic        rx_open;
	logic [6:0]  rx_count;
	logic [7:0]  rx_addr;
	logic [7:0]  rx_len;
	logic [7:0]  rx_func;
	logic [15:0] crc_calc;
	logic [15:0] crc_rcvd;
	logic [1:0]  crc_got;
	logic [15:0] tick_count;
	logic [7:0]  cfg_slave;
	logic [15:0] cfg_timeout;

	frr_result_t reply_q [$];
	frr_result_t want_reply;
	int mismatches = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	dir_row_t directed_rows [N_DIRECTED] = '{
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0055, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_TICK, 1'b0, 16'h00FF, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_FIXED, KIND_NACK_CRC, NACK_BYTE},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_FIXED, KIND_NACK_CRC, NACK_BYTE},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_TICK, 1'b0, 16'h00C5, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0002, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0071, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0080, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_PRED, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0001, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0005, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h000A, 8'd1, CHK_FIXED, KIND_NACK_CRC, NACK_BYTE},
		'{OP_CFG, REQ_BYTE, CFG_IDX_TIMEOUT, 16'h0002, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_TICK, 1'b0, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_TICK, 1'b0, 16'h00FF, 8'd1, CHK_FIXED, KIND_NACK_TMO, NACK_BYTE},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h00FF, 8'd63, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h00FF, 8'd1, CHK_FIXED, KIND_DROPPED, 8'h00},
		'{OP_CFG, REQ_BYTE, CFG_IDX_SLAVE_ID, 16'hA5FF, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_CFG, REQ_BYTE, CFG_IDX_TIMEOUT, 16'h0000, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_BYTE, 1'b0, 16'h003A, 8'd1, CHK_NONE, KIND_ACK, 8'h00},
		'{OP_ITEM, REQ_TICK, 1'b0, 16'h005A, 8'd1, CHK_FIXED, KIND_NACK_TMO, NACK_BYTE}
	};

	// bit-serial form of the reflected CRC-16 update
	function automatic logic [15:0] modbus_crc_update(input logic [15:0] acc,
		input logic [7:0] data);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = acc[0] ^ data[i];
			acc = acc >> 1;
			if (fb) acc = acc ^ 16'hA001;
		end
		return acc;
	endfunction

	function automatic void frame_clear();
		rx_open = 1'b0;
		rx_count = '0;
		rx_addr = 8'h00;
		rx_len = 8'h00;
		rx_func = 8'h00;
		crc_calc = CRC_INIT;
		crc_rcvd = 16'h0000;
		crc_got = 2'd0;
		tick_count = 16'h0000;
	endfunction

	function automatic bit predict_step(input frr_item_t it, output frr_result_t res);
		logic [7:0]  b;
		logic [7:0]  addr;
		logic [7:0]  len;
		logic [7:0]  fn;
		logic [15:0] calc;
		bit          have_addr;
		bit          crc_ok;
		int          idx;
		b = it.rx_byte;
		res = '0;
		if (it.req_type == REQ_TICK) begin
			if (!rx_open) return 1'b0;
			if (int'(tick_count) + 1 >= int'(cfg_timeout)) begin
				frame_clear();
				res = '{KIND_NACK_TMO, NACK_BYTE, 8'h00, 8'h00};
				return 1'b1;
			end
			tick_count = tick_count + 16'd1;
			return 1'b0;
		end
		if (!rx_open) begin
			if (b == HDR_BYTE) begin
				frame_clear();
				rx_open = 1'b1;
				rx_count = 7'd1;
			end
			return 1'b0;
		end
		tick_count = 16'h0000;
		if (b == END_BYTE) begin
			have_addr = (rx_count >= 7'd2);
			addr = rx_addr;
			len = rx_len;
			fn = rx_func;
			calc = (len == 8'h00) ? CRC_INIT : crc_calc;
			crc_ok = (crc_got == 2'd2) && (calc == crc_rcvd);
			frame_clear();
			if (!have_addr || addr != cfg_slave) return 1'b0;
			if (crc_ok) res = '{KIND_ACK, ACK_BYTE, fn, len};
			else res = '{KIND_NACK_CRC, NACK_BYTE, 8'h00, 8'h00};
			return 1'b1;
		end
		if (int'(rx_count) >= MAX_FRAME_BYTES) begin
			frame_clear();
			res = '{KIND_DROPPED, 8'h00, 8'h00, 8'h00};
			return 1'b1;
		end
		idx = int'(rx_count);
		if (idx == 1) begin
			rx_addr = b;
			crc_calc = modbus_crc_update(CRC_INIT, b);
		end else if (idx == 2) begin
			rx_len = b;
			if (b >= 8'd2) begin
				crc_calc = modbus_crc_update(crc_calc, b);
			end else if (b == 8'd0) begin
				crc_rcvd = {rx_addr, b};
				crc_got = 2'd2;
			end else begin
				crc_rcvd = {b, 8'h00};
				crc_got = 2'd1;
			end
		end else if (idx >= 3) begin
			if (idx == 3) rx_func = b;
			if (idx <= int'(rx_len)) begin
				crc_calc = modbus_crc_update(crc_calc, b);
			end else if (idx == int'(rx_len) + 1) begin
				crc_rcvd = {b, 8'h00};
				crc_got = 2'd1;
			end else if (idx == int'(rx_len) + 2) begin
				crc_rcvd = crc_rcvd | {8'h00, b};
				crc_got = 2'd2;
			end
		end
		rx_count = rx_count + 7'd1;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (mismatches < 100)
			$display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
		mismatches++;
	endtask

	task automatic push_item(input frr_item_t it, input check_t chk, input frr_result_t typed);
		frr_result_t pred;
		bit          has;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.rx_byte <= it.rx_byte;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		has = predict_step(it, pred);
		if (chk == CHK_PRED && has) reply_q.push_back(pred);
		else if (chk == CHK_FIXED) reply_q.push_back(typed);
		items_sent++;
	endtask

	// drain in-flight transactions, then one register write
	task automatic write_one(input logic idx, input logic [15:0] data);
		req_ch.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx == CFG_IDX_SLAVE_ID) cfg_slave = data[7:0];
		else cfg_timeout = data;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_tick();
		frr_item_t it;
		it.req_type = REQ_TICK;
		it.rx_byte = 8'($urandom_range(255));
		push_item(it, CHK_PRED, '0);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit sprinkle);
		frr_item_t it;
		if (sprinkle && $urandom_range(99) < 6) repeat ($urandom_range(1, 3)) send_tick();
		it.req_type = REQ_BYTE;
		it.rx_byte = b;
		push_item(it, CHK_PRED, '0);
	endtask

	function automatic logic [7:0] rand_body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == END_BYTE) b = HDR_BYTE;
		return b;
	endfunction

	task automatic gen_burst();
		logic [7:0]  body [$];
		logic [7:0]  b;
		logic [7:0]  addr;
		logic [7:0]  len;
		logic [15:0] crc;
		int          pick;
		int          n;
		int          r;
		int          cut;
		pick = $urandom_range(99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(1) == 1) begin
					send_tick();
				end else begin
					b = 8'($urandom_range(255));
					if ($urandom_range(3) == 0) b = $urandom_range(1) ? HDR_BYTE : END_BYTE;
					send_byte(b, 1'b0);
				end
			end
		end else if (pick < 17) begin
			send_byte(HDR_BYTE, 1'b0);
			repeat ($urandom_range(62, 68)) send_byte(rand_body_byte(), 1'b0);
			if ($urandom_range(1) == 1) send_byte(END_BYTE, 1'b0);
		end else if (pick < 24) begin
			send_byte(HDR_BYTE, 1'b0);
			repeat ($urandom_range(0, 4)) send_byte(rand_body_byte(), 1'b0);
			if (cfg_timeout <= 16'd40) n = int'(cfg_timeout) + $urandom_range(0, 2);
			else n = $urandom_range(1, 5);
			if (n == 0) n = 1;
			repeat (n) send_tick();
		end else begin
			addr = ($urandom_range(99) < 85) ? cfg_slave : 8'($urandom_range(255));
			r = $urandom_range(99);
			if (r < 75) len = 8'($urandom_range(2, 10));
			else if (r < 85) len = 8'($urandom_range(0, 1));
			else if (r < 95) len = 8'($urandom_range(11, 24));
			else len = 8'($urandom_range(40, 61));
			body.push_back(addr);
			body.push_back(len);
			for (int i = 3; i <= int'(len); i++) body.push_back(rand_body_byte());
			if (len >= 8'd2) begin
				crc = CRC_INIT;
				foreach (body[i]) crc = modbus_crc_update(crc, body[i]);
				body.push_back(crc[15:8]);
				body.push_back(crc[7:0]);
			end else begin
				body.push_back(rand_body_byte());
				body.push_back(rand_body_byte());
			end
			if (pick >= 76 && pick < 88) begin
				cut = $urandom_range(0, body.size() - 1);
				body[cut] = body[cut] ^ 8'($urandom_range(1, 255));
			end else if (pick >= 88) begin
				cut = $urandom_range(0, body.size() - 1);
				while (body.size() > cut) void'(body.pop_back());
			end
			if ($urandom_range(99) < 5) body.push_back(rand_body_byte());
			send_byte(HDR_BYTE, 1'b1);
			foreach (body[i]) send_byte(body[i], 1'b1);
			send_byte(END_BYTE, 1'b1);
		end
	endtask

	always @(posedge clk) rep_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

	always @(posedge clk) begin
		if (arst_n && rep_ch.valid && rep_ch.ready) begin
			if (reply_q.size() == 0) begin
				report_mismatch("reply with no request pending", {14'h0, rep_ch.reply_kind},
					16'h0);
			end else begin
				want_reply = reply_q.pop_front();
				if (rep_ch.reply_kind != want_reply.reply_kind)
					report_mismatch("reply_kind", {14'h0, rep_ch.reply_kind},
						{14'h0, want_reply.reply_kind});
				if (rep_ch.reply_byte != want_reply.reply_byte)
					report_mismatch("reply_byte", {8'h0, rep_ch.reply_byte},
						{8'h0, want_reply.reply_byte});
				if (rep_ch.function_code != want_reply.function_code)
					report_mismatch("function_code", {8'h0, rep_ch.function_code},
						{8'h0, want_reply.function_code});
				if (rep_ch.pdu_length != want_reply.pdu_length)
					report_mismatch("pdu_length", {8'h0, rep_ch.pdu_length},
						{8'h0, want_reply.pdu_length});
			end
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rep_ch.valid && rep_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("framed_request_receiver_crc16_unit verification failed");
			$finish;
		end
	end

	initial begin
		frr_item_t   it;
		frr_result_t typed;
		logic [7:0]  slave_v;
		logic [15:0] tmo_v;
		int          target;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_BYTE;
		req_ch.rx_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_IDX_SLAVE_ID;
		cfg_ch.data <= 16'h0000;
		frame_clear();
		cfg_slave = 8'h00;
		cfg_timeout = TIMEOUT_RESET;
		src_idle_pct = 36;
		sink_idle_pct = 52;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].op == OP_CFG) begin
				write_one(directed_rows[i].cfg_index, directed_rows[i].value);
			end else begin
				it.req_type = directed_rows[i].req_type;
				it.rx_byte = directed_rows[i].value[7:0];
				typed = '{directed_rows[i].kind, directed_rows[i].rbyte, 8'h00, 8'h00};
				repeat (directed_rows[i].reps) push_item(it, directed_rows[i].chk, typed);
			end
		end

		for (int seg = 0; seg < 9; seg++) begin
			case (seg / 3)
				0: begin
					src_idle_pct = 36;
					sink_idle_pct = 52;
				end
				1: begin
					src_idle_pct = 52;
					sink_idle_pct = 36;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			slave_v = 8'($urandom_range(255));
			case (seg)
				0: begin
					slave_v = 8'h00;
					tmo_v = 16'hFFFF;
				end
				1: begin
					slave_v = 8'hFF;
					tmo_v = 16'd1;
				end
				2: tmo_v = 16'($urandom_range(2, 20));
				3: tmo_v = TIMEOUT_RESET;
				4: begin
					slave_v = 8'hFF;
					tmo_v = 16'd0;
				end
				5: tmo_v = 16'($urandom_range(1, 8));
				6: begin
					slave_v = 8'h00;
					tmo_v = 16'($urandom_range(3, 40));
				end
				7: tmo_v = 16'hFFFF;
				default: tmo_v = 16'($urandom_range(1, 65535));
			endcase
			write_one(CFG_IDX_SLAVE_ID, {8'($urandom_range(255)), slave_v});
			write_one(CFG_IDX_TIMEOUT, tmo_v);
			target = items_sent + SEG_ITEMS;
			while (items_sent < target) gen_burst();
		end

		req_ch.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("framed_request_receiver_crc16_unit verification clean");
		else
			$display("framed_request_receiver_crc16_unit verification failed");
		$finish;
	end

endmodule
